// ===== design/sst_pkg.sv =====
// shared types and constants of the sum segment tree unit
// no dependencies; imported by every module of the block except sst_ram
package sst_pkg;

    localparam int MAX_LEAVES = 1024;
    localparam int NODE_COUNT = 2 * MAX_LEAVES;
    localparam int NODE_AW    = $clog2(NODE_COUNT);
    localparam int IDX_W      = NODE_AW + 1;
    localparam int CNT_W      = $clog2(MAX_LEAVES + 1);
    localparam int DATA_W     = 32;
    localparam int POS_W      = 10;
    localparam int LEAF_W     = 11;
    localparam int BND_W      = (LEAF_W > IDX_W) ? LEAF_W : IDX_W;

    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;
    localparam logic REG_LEAF_COUNT = 1'b0;
    localparam logic [LEAF_W-1:0] LEAF_RESET = LEAF_W'(1024);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_QRY
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] leaves;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] sum;
    } t_res;

endpackage

// ===== design/sst_ram.sv =====
// generic synchronous ram: one write port, two registered read ports
// no dependencies
module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== design/sst_cfg.sv =====
// apb register block holding leaf_count and its clamped effective value
// depends on sst_pkg
module sst_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [sst_pkg::APB_AW-1:0] paddr,
    input  logic [sst_pkg::APB_DW-1:0] pwdata,
    output logic [sst_pkg::APB_DW-1:0] prdata,
    output logic                      pready,
    output sst_pkg::t_cfg             o_cfg
);
    import sst_pkg::*;

    localparam int CMP_W = (LEAF_W > CNT_W) ? LEAF_W : CNT_W;

    logic [LEAF_W-1:0] r_leaf_count;
    logic              w_sel_leaf;
    logic [CMP_W-1:0]  w_lc;

    assign w_sel_leaf = (paddr[APB_AW-1] == REG_LEAF_COUNT);
    assign pready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaf_count <= LEAF_RESET;
        end else if (psel && penable && pwrite && w_sel_leaf) begin
            r_leaf_count <= pwdata[LEAF_W-1:0];
        end
    end

    assign prdata = w_sel_leaf ? APB_DW'(r_leaf_count) : '0;

    // zero counts as one leaf, large counts saturate
    assign w_lc = CMP_W'(r_leaf_count);
    always_comb begin
        priority if (w_lc == '0) begin
            o_cfg.leaves = CNT_W'(1);
        end else if (w_lc > CMP_W'(MAX_LEAVES)) begin
            o_cfg.leaves = CNT_W'(MAX_LEAVES);
        end else begin
            o_cfg.leaves = CNT_W'(w_lc);
        end
    end

endmodule

// ===== design/sst_engine.sv =====
// tree sequencer: clearing pass, leaf update with ancestor rebuild, range query
// depends on sst_pkg and sst_ram
module sst_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sst_pkg::t_cfg               i_cfg,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_mode,
    input  logic [sst_pkg::POS_W-1:0]   i_position,
    input  logic [sst_pkg::DATA_W-1:0]  i_new_value,
    input  logic [sst_pkg::LEAF_W-1:0]  i_range_begin,
    input  logic [sst_pkg::LEAF_W-1:0]  i_range_end,
    input  logic                        i_res_free,
    output sst_pkg::t_res               o_res
);
    import sst_pkg::*;

    t_state              r_state, n_state;
    logic [NODE_AW-1:0]  r_clr, n_clr;
    logic [NODE_AW-1:0]  r_k, n_k;
    logic [IDX_W-1:0]    r_lo, n_lo, r_hi, n_hi;
    logic [DATA_W-1:0]   r_acc, n_acc;
    logic [1:0]          r_pend, n_pend;

    logic                we;
    logic [NODE_AW-1:0]  waddr, raddr_a, raddr_b;
    logic [DATA_W-1:0]   wdata, rdata_a, rdata_b, w_contrib;

    logic [BND_W-1:0]    w_n, w_pos, w_beg, w_end, w_lo0, w_hi0;
    logic [NODE_AW-1:0]  w_k0, w_k0_par, w_k_par;
    logic [IDX_W-1:0]    w_qlo, w_qhi, w_hi_dec;
    logic                w_accept;

    sst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NODE_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    assign w_n      = BND_W'(i_cfg.leaves);
    assign w_pos    = BND_W'(i_position);
    assign w_beg    = BND_W'(i_range_begin);
    assign w_end    = BND_W'(i_range_end);
    assign w_lo0    = (w_beg > w_n) ? w_n : w_beg;
    assign w_hi0    = (w_end > w_n) ? w_n : w_end;
    assign w_k0     = NODE_AW'(w_pos + w_n);
    assign w_k0_par = w_k0 >> 1;
    assign w_k_par  = r_k >> 1;
    assign w_qlo    = IDX_W'(w_lo0 + w_n);
    assign w_qhi    = IDX_W'(w_hi0 + w_n);
    assign w_hi_dec = r_hi - IDX_W'(1);

    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);

    // reads issued last cycle are folded in now
    assign w_contrib = r_acc + (r_pend[0] ? rdata_a : '0) + (r_pend[1] ? rdata_b : '0);

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_k       = r_k;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_acc     = w_contrib;
        n_pend    = 2'b00;
        we        = 1'b0;
        waddr     = w_k0;
        wdata     = i_new_value;
        raddr_a   = {r_k[NODE_AW-2:0], 1'b0};
        raddr_b   = {r_k[NODE_AW-2:0], 1'b1};
        o_res.valid = 1'b0;
        o_res.sum   = r_acc;
        unique case (r_state)
            ST_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = '0;
                n_clr = r_clr + NODE_AW'(1);
                if (r_clr == NODE_AW'(NODE_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept && !i_mode) begin
                    // out-of-range positions are dropped
                    if (w_pos < w_n) begin
                        we  = 1'b1;
                        n_k = w_k0_par;
                        if (w_k0_par != '0) begin
                            n_state = ST_UPD_RD;
                        end
                    end
                end else if (w_accept) begin
                    n_lo    = w_qlo;
                    n_hi    = w_qhi;
                    n_acc   = '0;
                    n_state = ST_QRY;
                end
            end
            ST_UPD_RD: begin
                n_state = ST_UPD_WR;
            end
            ST_UPD_WR: begin
                we    = 1'b1;
                waddr = r_k;
                wdata = rdata_a + rdata_b;
                n_k   = w_k_par;
                n_state = (w_k_par == '0) ? ST_IDLE : ST_UPD_RD;
            end
            ST_QRY: begin
                raddr_a = r_lo[NODE_AW-1:0];
                raddr_b = w_hi_dec[NODE_AW-1:0];
                if (r_lo < r_hi) begin
                    n_pend = {r_hi[0], r_lo[0]};
                    n_lo   = (r_lo + IDX_W'(r_lo[0])) >> 1;
                    n_hi   = (r_hi - IDX_W'(r_hi[0])) >> 1;
                end else if (r_pend == 2'b00) begin
                    o_res.valid = 1'b1;
                    if (i_res_free) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_pend  <= 2'b00;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_acc <= n_acc;
    end

endmodule

// ===== design/sum_segment_tree_unit.sv =====
// top level of the sum segment tree unit: config registers, tree engine, result register
// depends on sst_pkg, sst_cfg, sst_engine (and through it sst_ram)
//
// usage:
// - input channel (i_in_valid / o_in_stall): one request per item; mode 0 writes
//   new_value at leaf position and rebuilds its ancestors, mode 1 sums the leaves
//   in [range_begin, range_end) and yields one result on o_range_sum
// - output channel (o_out_valid / i_out_stall): one result per query request,
//   none per update; results leave in request order
// - apb port: leaf_count at byte address 0; the user must write it only while
//   the block is idle, the block itself does not enforce this
// - update: accept cycle writes the leaf, then each ancestor level takes a read state
//   and a write state (read both children, write the sum)
// - query: walks the tree one level per step on the two ram read ports, then
//   drains the last reads and registers the sum
// - reset: a clearing pass writes zero to all 2048 nodes, one per cycle, and the
//   input is stalled until it ends; apb writes work throughout
// - stall on the output holds the result register; a query that finishes while
//   it is still full waits, and the next request is taken once it has moved
module sum_segment_tree_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic [sst_pkg::POS_W-1:0]         i_position,
    input  logic signed [sst_pkg::DATA_W-1:0] i_new_value,
    input  logic [sst_pkg::LEAF_W-1:0]        i_range_begin,
    input  logic [sst_pkg::LEAF_W-1:0]        i_range_end,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [sst_pkg::DATA_W-1:0] o_range_sum,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sst_pkg::APB_AW-1:0]        paddr,
    input  logic [sst_pkg::APB_DW-1:0]        pwdata,
    output logic [sst_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);
    import sst_pkg::*;

    t_cfg              w_cfg;
    t_res              w_res;
    logic              w_res_free;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_sum;

    sst_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sst_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_position    (i_position),
        .i_new_value   ($unsigned(i_new_value)),
        .i_range_begin (i_range_begin),
        .i_range_end   (i_range_end),
        .i_res_free    (w_res_free),
        .o_res         (w_res)
    );

    // result register frees up when empty or being taken this cycle
    assign w_res_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_free) begin
            r_out_valid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_free && w_res.valid) begin
            r_out_sum <= w_res.sum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_range_sum = $signed(r_out_sum);

endmodule

// ===== design/sst_checker.sv =====
// port-level checks for the sum segment tree unit, bound to the top level
// depends on sst_pkg
module sst_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              i_mode,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic signed [sst_pkg::DATA_W-1:0] o_range_sum,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [sst_pkg::APB_AW-1:0]        paddr,
    input logic [sst_pkg::APB_DW-1:0]        pwdata,
    input logic [sst_pkg::APB_DW-1:0]        prdata
);
    import sst_pkg::*;

    // clearing pass keeps the input closed right after reset
    a_clear_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input open right after reset");

    // a query can never produce its result in the very next cycle
    a_query_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_mode && !o_out_valid) |=> !o_out_valid)
        else $error("query result appeared too early");

    // leaf_count reads back what was written
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && (paddr[APB_AW-1] == REG_LEAF_COUNT))
        |=> ((paddr[APB_AW-1] != REG_LEAF_COUNT) ||
             (prdata[LEAF_W-1:0] == $past(pwdata[LEAF_W-1:0]))))
        else $error("leaf_count readback mismatch");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_range_sum)))
        else $error("stalled result changed");

endmodule

bind sum_segment_tree_unit sst_checker u_sst_checker (.*);
